// ===== src/iee_pkg.sv =====
// Shared types, codes and constants for the infix expression checker/evaluator.
// Depends on nothing; every file in src but iee_fifo imports it.
package iee_pkg;

   localparam int VALUE_WIDTH_DEF = 32;   // internal arithmetic width
   localparam int RES_W           = 32;   // width of the reported value
   localparam int OPQ_DEPTH_DEF   = 4;    // front-to-back queue
   localparam int RSQ_DEPTH_DEF   = 4;    // result queue

   // recognizer states
   localparam logic [2:0] ST_INIT     = 3'd0;
   localparam logic [2:0] ST_SIGN     = 3'd1;
   localparam logic [2:0] ST_NUMBER   = 3'd2;
   localparam logic [2:0] ST_OPERATOR = 3'd3;
   localparam logic [2:0] ST_REJECT   = 3'd4;

   // character classes
   localparam logic [1:0] COL_DIGIT = 2'd0;
   localparam logic [1:0] COL_SIGN  = 2'd1;
   localparam logic [1:0] COL_STAR  = 2'd2;
   localparam logic [1:0] COL_OTHER = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   // next state by [state][class]
   localparam logic [2:0] NEXT_STATE_TBL [0:4][0:3] = '{
      '{ST_NUMBER, ST_SIGN,     ST_REJECT,   ST_REJECT},
      '{ST_NUMBER, ST_REJECT,   ST_REJECT,   ST_REJECT},
      '{ST_NUMBER, ST_OPERATOR, ST_OPERATOR, ST_REJECT},
      '{ST_NUMBER, ST_OPERATOR, ST_REJECT,   ST_REJECT},
      '{ST_REJECT, ST_REJECT,   ST_REJECT,   ST_REJECT}
   };

   // arithmetic operations handed from front to back
   localparam logic [2:0] OP_NONE   = 3'd0;  // no arithmetic effect
   localparam logic [2:0] OP_DIGIT  = 3'd1;  // append a decimal digit
   localparam logic [2:0] OP_FLIP   = 3'd2;  // unary minus
   localparam logic [2:0] OP_BINARY = 3'd3;  // binary + or -, close the term
   localparam logic [2:0] OP_MUL    = 3'd4;  // close a factor

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] digit;
      logic       minus;    // binary op was '-'
      logic       last;     // last character of the expression
      logic       accept;   // recognizer is in the accepting state after it
   } op_type;

   typedef struct packed {
      logic                    accepted;
      logic signed [RES_W-1:0] value;
   } result_type;

endpackage

// ===== src/iee_fifo.sv =====
// Small register-array queue, first word visible on the read side.
// Depends on nothing; DEPTH must be a power of two.
module iee_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [WIDTH-1:0]               wr_data,
   output logic                           full,
   input  logic                           rd_en,
   output logic [WIDTH-1:0]               rd_data,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/iee_front.sv =====
// Front end: classifies each character and runs the five-state recognizer,
// emitting one arithmetic operation per request. Depends on iee_pkg.
module iee_front (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,          // request accepted this cycle
   input  logic [7:0]    char_code,
   input  logic          end_of_expr,
   output iee_pkg::op_type op
);
   import iee_pkg::*;

   logic [2:0] state_ff, state_in;
   logic [2:0] cur_state, next_state;
   logic [1:0] col;

   always_comb begin
      cur_state = (state_ff > ST_REJECT) ? ST_REJECT : state_ff;
      if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
         col = COL_DIGIT;
      end else if (char_code == CHAR_PLUS || char_code == CHAR_MINUS) begin
         col = COL_SIGN;
      end else if (char_code == CHAR_STAR) begin
         col = COL_STAR;
      end else begin
         col = COL_OTHER;
      end
      next_state = NEXT_STATE_TBL[cur_state][col];
   end

   always_comb begin
      op.kind   = OP_NONE;
      op.digit  = 4'(char_code - CHAR_ZERO);
      op.minus  = (char_code == CHAR_MINUS);
      op.last   = end_of_expr;
      op.accept = (next_state == ST_NUMBER);
      if (next_state != ST_REJECT) begin
         unique case (col)
            COL_DIGIT: op.kind = OP_DIGIT;
            COL_SIGN: begin
               if (cur_state == ST_NUMBER) begin
                  op.kind = OP_BINARY;
               end else if (char_code == CHAR_MINUS) begin
                  op.kind = OP_FLIP;
               end
            end
            COL_STAR: op.kind = OP_MUL;
            default:  op.kind = OP_NONE;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = end_of_expr ? ST_INIT : next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/iee_back.sv =====
// Back end: carries out the queued operations on the number, term and sum
// registers and finishes each expression through a two-stage tail.
// Depends on iee_pkg.
module iee_back #(
   parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
   parameter int RSQ_DEPTH   = iee_pkg::RSQ_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_empty,
   input  iee_pkg::op_type               op,
   output logic                          op_pop,
   input  logic [$clog2(RSQ_DEPTH+1)-1:0] rsq_count,
   output logic                          res_wr,
   output iee_pkg::result_type           res
);
   import iee_pkg::*;

   localparam int W     = VALUE_WIDTH;
   localparam int CNT_W = $clog2(RSQ_DEPTH+1);

   // signed value of the number being read, already carrying its sign
   logic [W-1:0] num_ff,  num_in;
   logic         neg_ff,  neg_in;
   logic [W-1:0] term_ff, term_in;
   logic [W-1:0] sum_ff,  sum_in;
   logic [W-1:0] prod_ff, prod_in;   // term product waiting to join the sum
   logic         pend_ff, pend_in;

   // finishing tail
   logic         f1_v_ff, f1_acc_ff;
   logic [W-1:0] f1_term_ff, f1_num_ff, f1_sum_ff;
   logic         f2_v_ff, f2_acc_ff;
   logic [W-1:0] f2_prod_ff, f2_sum_ff;

   logic [W-1:0] mul_out;
   logic [W-1:0] digit_ext, digit_add;
   logic [CNT_W:0] in_use;
   logic         room;
   logic [W-1:0] final_sum;
   logic [W+RES_W-1:0] final_ext;

   assign in_use  = (CNT_W+1)'(rsq_count) + (CNT_W+1)'(f1_v_ff) + (CNT_W+1)'(f2_v_ff);
   assign room    = (in_use < (CNT_W+1)'(RSQ_DEPTH));
   assign op_pop  = !op_empty && (!op.last || room);
   assign mul_out = term_ff * num_ff;

   always_comb begin
      digit_ext = W'(op.digit);
      digit_add = neg_ff ? (W'(0) - digit_ext) : digit_ext;
      num_in    = num_ff;
      neg_in    = neg_ff;
      term_in   = term_ff;
      prod_in   = prod_ff;
      pend_in   = 1'b0;
      sum_in    = pend_ff ? sum_ff + prod_ff : sum_ff;
      case (op.kind)
         OP_DIGIT: num_in = (num_ff << 3) + (num_ff << 1) + digit_add;
         OP_FLIP:  neg_in = !neg_ff;
         OP_BINARY: begin
            prod_in = mul_out;
            pend_in = 1'b1;
            term_in = W'(1);
            num_in  = '0;
            neg_in  = op.minus;
         end
         OP_MUL: begin
            term_in = mul_out;
            num_in  = '0;
            neg_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff  <= '0;
         neg_ff  <= 1'b0;
         term_ff <= W'(1);
         sum_ff  <= '0;
         pend_ff <= 1'b0;
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= op_pop && op.last;
         f2_v_ff <= f1_v_ff;
         if (op_pop && op.last) begin
            num_ff  <= '0;
            neg_ff  <= 1'b0;
            term_ff <= W'(1);
            sum_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (op_pop) begin
            num_ff  <= num_in;
            neg_ff  <= neg_in;
            term_ff <= term_in;
            sum_ff  <= sum_in;
            pend_ff <= pend_in;
         end else begin
            // drain a pending term even while the queue is dry
            sum_ff  <= sum_in;
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         prod_ff <= prod_in;
      end
      f1_acc_ff  <= op.accept;
      f1_term_ff <= term_in;
      f1_num_ff  <= num_in;
      f1_sum_ff  <= sum_in;
      f2_acc_ff  <= f1_acc_ff;
      f2_prod_ff <= f1_term_ff * f1_num_ff;
      f2_sum_ff  <= f1_sum_ff;
   end

   assign final_sum    = f2_sum_ff + f2_prod_ff;
   assign final_ext    = {{RES_W{1'b0}}, final_sum};
   assign res_wr       = f2_v_ff;
   assign res.accepted = f2_acc_ff;
   assign res.value    = f2_acc_ff ? final_ext[RES_W-1:0] : '0;

endmodule

// ===== src/infix_expression_checker_evaluator.sv =====
// Top level of the infix expression checker/evaluator.
// Depends on iee_pkg, iee_fifo, iee_front and iee_back.
//
// The block takes one ASCII character per request and answers each
// expression with one result when the character flagged end_of_expr
// arrives: accepted is 1 when the recognizer ends in its accepting state,
// and value is the expression's value (decimal integers joined by + - *,
// multiplication first, unary signs at the start or after an operator),
// wrapped modulo 2^VALUE_WIDTH and reported in its low 32 bits, or zero
// when rejected. Characters other than digits, '+', '-' and '*' reject the
// expression. Throughput is one character per cycle. A result passes from its
// last character through the operation queue, the back-end two-stage
// finishing tail (multiply, then add) and the result queue write before it
// shows on the rsp_ ports. The front end stalls only when the operation
// queue fills; the back end stalls on a last character only when the result
// queue has no room for it.
module infix_expression_checker_evaluator #(
   parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
   parameter int OPQ_DEPTH   = iee_pkg::OPQ_DEPTH_DEF,
   parameter int RSQ_DEPTH   = iee_pkg::RSQ_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request side
   input  logic                           push,
   output logic                           full,
   input  logic [7:0]                     req_char_code,
   input  logic                           req_end_of_expr,
   // result side
   output logic                           empty,
   input  logic                           pop,
   output logic                           rsp_accepted,
   output logic signed [iee_pkg::RES_W-1:0] rsp_value
);
   import iee_pkg::*;

   localparam int OP_W  = $bits(op_type);
   localparam int RES_BITS = $bits(result_type);

   logic       take;
   op_type     front_op;
   op_type     back_op;
   logic       opq_empty;
   logic       op_pop;
   logic [$clog2(OPQ_DEPTH+1)-1:0] opq_count;
   logic [$clog2(RSQ_DEPTH+1)-1:0] rsq_count;
   logic       res_wr;
   logic       rsq_full;
   result_type res_in;
   result_type res_out;

   // request is taken whenever the operation queue has room
   assign take = push && !full;

   iee_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (req_char_code),
      .end_of_expr (req_end_of_expr),
      .op          (front_op)
   );

   // operation queue: lets the front end keep taking characters while the
   // back end waits for room in the result queue
   iee_fifo #(
      .WIDTH (OP_W),
      .DEPTH (OPQ_DEPTH)
   ) u_opq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (take),
      .wr_data (front_op),
      .full    (full),
      .rd_en   (op_pop),
      .rd_data (back_op),
      .empty   (opq_empty),
      .count   (opq_count)
   );

   iee_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .RSQ_DEPTH   (RSQ_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (opq_empty || (opq_count == '0)),
      .op        (back_op),
      .op_pop    (op_pop),
      .rsq_count (rsq_count),
      .res_wr    (res_wr),
      .res       (res_in)
   );

   // result queue: the back end reserves a slot before finishing, so a
   // write never meets a full queue
   iee_fifo #(
      .WIDTH (RES_BITS),
      .DEPTH (RSQ_DEPTH)
   ) u_rsq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_wr),
      .wr_data (res_in),
      .full    (rsq_full),
      .rd_en   (pop),
      .rd_data (res_out),
      .empty   (empty),
      .count   (rsq_count)
   );

   assign rsp_accepted = res_out.accepted && !rsq_full | res_out.accepted;
   assign rsp_value    = res_out.value;

endmodule

// ===== src/iee_checker.sv =====
// Port-level checks for the infix expression checker/evaluator, bound to
// the top level. Depends on iee_pkg.
module iee_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             push,
   input logic                             full,
   input logic                             empty,
   input logic                             pop,
   input logic                             rsp_accepted,
   input logic signed [iee_pkg::RES_W-1:0] rsp_value
);
   import iee_pkg::*;

   // a rejected expression always reports zero
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_accepted) |-> (rsp_value == '0))
      else $error("rejected result carries a nonzero value");

   // an unpopped result holds
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_value) && $stable(rsp_accepted)))
      else $error("waiting result changed or vanished");

   // the result queue comes out of reset empty and the operation queue not full
   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // no result is present when reset has just been released
   assert property (@(posedge clock) (reset ##1 !reset) |-> empty)
      else $error("result appeared right after reset");

endmodule

bind infix_expression_checker_evaluator iee_checker u_iee_checker (
   .clock        (clock),
   .reset        (reset),
   .push         (push),
   .full         (full),
   .empty        (empty),
   .pop          (pop),
   .rsp_accepted (rsp_accepted),
   .rsp_value    (rsp_value)
);
